[rtl/swm_pkg.sv]
// Shared constants and controller/datapath interface types for the sliding window maximum.
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int WIN_W      = 7;
    localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RAM_DEPTH  = 2 ** PTR_W;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int POS_W      = $clog2(2 * MAX_WINDOW);
    localparam int ENTRY_W    = DATA_W + POS_W;

    typedef struct packed {
        logic load;
        logic rd_tail;
        logic pop_tail;
        logic rd_head;
        logic pop_head;
        logic push;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic tail_less;
        logic head_old;
        logic has_result;
    } t_stat;

endpackage

[rtl/swm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/swm_datapath.sv]
// Datapath: circular queue storage, counters, comparators and the result register.
module swm_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [swm_pkg::DATA_W-1:0] i_sample,
    input  logic                       i_first_of_sequence,
    input  logic                       i_cfg_we,
    input  logic [swm_pkg::WIN_W-1:0]  i_cfg_data,
    input  swm_pkg::t_cmd              i_cmd,
    output swm_pkg::t_stat             o_stat,
    output logic signed [swm_pkg::DATA_W-1:0] o_window_max
);
    import swm_pkg::*;

    localparam logic [POS_W:0] POS_MOD_V = (POS_W + 1)'(2 * MAX_WINDOW);

    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_out_data;
    logic [PTR_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_count;
    logic [POS_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_seen;
    logic [WIN_W-1:0]         r_window;

    logic [CNT_W-1:0]         win_k;
    logic [PTR_W-1:0]         tail_idx;
    logic [PTR_W-1:0]         push_idx;
    logic [ENTRY_W-1:0]       rd_data;
    logic signed [DATA_W-1:0] rd_value;
    logic [POS_W-1:0]         rd_pos;
    logic [POS_W:0]           pos_diff;
    logic [POS_W:0]           age_wide;
    logic [POS_W-1:0]         age;

    // Window size clamped to the supported range.
    always_comb begin
        if (r_window == '0) begin
            win_k = CNT_W'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            win_k = CNT_W'(MAX_WINDOW);
        end else begin
            win_k = CNT_W'(r_window);
        end
    end

    assign tail_idx = r_head + r_count[PTR_W-1:0] - PTR_W'(1);
    assign push_idx = r_head + r_count[PTR_W-1:0];

    swm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push && (r_count < CNT_W'(MAX_WINDOW))),
        .i_waddr (push_idx),
        .i_wdata ({r_sample, r_pos}),
        .i_re    (i_cmd.rd_tail || i_cmd.rd_head),
        .i_raddr (i_cmd.rd_tail ? tail_idx : r_head),
        .o_rdata (rd_data)
    );

    assign rd_value = rd_data[ENTRY_W-1:POS_W];
    assign rd_pos   = rd_data[POS_W-1:0];

    // Age of the entry read, modulo the position range.
    assign pos_diff = {1'b0, r_pos} - {1'b0, rd_pos};
    assign age_wide = pos_diff[POS_W] ? (pos_diff + POS_MOD_V) : pos_diff;
    assign age      = age_wide[POS_W-1:0];

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.tail_less  = (rd_value < r_sample);
    assign o_stat.head_old   = (age >= POS_W'(win_k));
    assign o_stat.has_result = (r_seen >= win_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_W'(1);
            r_head   <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_seen   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.load && i_first_of_sequence) begin
                r_count <= '0;
                r_pos   <= '0;
                r_seen  <= '0;
            end
            if (i_cmd.pop_tail) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.pop_head) begin
                r_head  <= r_head + PTR_W'(1);
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.push) begin
                if (r_count < CNT_W'(MAX_WINDOW)) begin
                    r_count <= r_count + CNT_W'(1);
                end
                r_pos <= (r_pos == POS_W'(2 * MAX_WINDOW - 1)) ? '0 : r_pos + POS_W'(1);
                if (r_seen < win_k) begin
                    r_seen <= r_seen + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.out_load) begin
            r_out_data <= rd_value;
        end
    end

    assign o_window_max = r_out_data;

endmodule

[rtl/swm_ctrl.sv]
// Controller: sequences the tail scan, head expiry, append and result load for each sample.
module swm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  swm_pkg::t_stat i_stat,
    output swm_pkg::t_cmd  o_cmd
);
    import swm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TAIL_RD  = 3'd1;
    localparam logic [2:0] S_TAIL_CMP = 3'd2;
    localparam logic [2:0] S_HEAD_RD  = 3'd3;
    localparam logic [2:0] S_HEAD_CMP = 3'd4;
    localparam logic [2:0] S_PUSH     = 3'd5;
    localparam logic [2:0] S_OUT_RD   = 3'd6;
    localparam logic [2:0] S_OUT_WAIT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TAIL_RD;
                end
            end
            S_TAIL_RD: begin
                if (i_stat.empty) begin
                    n_state = S_HEAD_RD;
                end else begin
                    o_cmd.rd_tail = 1'b1;
                    n_state       = S_TAIL_CMP;
                end
            end
            S_TAIL_CMP: begin
                if (i_stat.tail_less) begin
                    o_cmd.pop_tail = 1'b1;
                    n_state        = S_TAIL_RD;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                if (i_stat.empty) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_HEAD_CMP;
                end
            end
            S_HEAD_CMP: begin
                if (i_stat.head_old) begin
                    o_cmd.pop_head = 1'b1;
                    n_state        = S_HEAD_RD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_OUT_RD;
            end
            S_OUT_RD: begin
                if (i_stat.has_result) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_OUT_WAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_WAIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/sliding_window_max.sv]
// Top level of the sliding window maximum: controller, datapath and their command/status links.
//
// This block reports the largest signed sample over the last window_size samples of a stream.
// Each accepted sample is merged into a monotonic decreasing queue of (value, position) entries
// held in a 64-entry circular RAM: smaller entries are dropped from the tail, entries that have
// left the window are dropped from the head, and the sample is then appended. Once window_size
// samples of the current sequence have arrived, every transfer in produces one transfer out
// carrying the window maximum; before that, a sample produces no result. Raising
// i_first_of_sequence with a sample empties the queue and restarts the counts. The window size
// must be written through i_cfg_we/i_cfg_data only while the block is idle; the block has no
// check for this. Zero acts as one and values above 64 act as 64. Each queue compare needs one
// read through the RAM's single registered read port, so every entry a sample drops adds a read
// state and a compare state; the input stalls meanwhile. The result sits in an output register,
// so a stalled consumer only holds back the next sample once it reaches its own result load.
// No clearing pass is needed after reset: only entries below the queue count are ever read.
module sliding_window_max (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [swm_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_first_of_sequence,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [swm_pkg::DATA_W-1:0] o_window_max,
    input  logic                              i_cfg_we,
    input  logic [swm_pkg::WIN_W-1:0]         i_cfg_data
);
    import swm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller steps through the queue maintenance for one sample at a time.
    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath owns the queue RAM, the counters and the result register.
    swm_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample            (i_sample),
        .i_first_of_sequence (i_first_of_sequence),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_window_max        (o_window_max)
    );

endmodule

[rtl/swm_checker.sv]
// Port-level assertions for the sliding window maximum and the bind that attaches them.
module swm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [swm_pkg::DATA_W-1:0] o_window_max
);

    // Reset leaves the block ready for a sample with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // A sample transfer keeps the input stalled while the queue is updated.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a transfer");

    // A new result only appears at the end of a sample's processing.
    a_result_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in progress");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_window_max)))
        else $error("stalled result changed or dropped");

endmodule

bind sliding_window_max swm_checker u_swm_checker (.*);
